@@ sv/pfp_pkg.sv @@
package pfp_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int CORDIC_W          = 36;
    localparam int QUO_W             = 32;
    localparam int NUM_W             = 65;
    localparam int DEN_W             = 32;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 8;

    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] ONE_Q30      = 32'h4000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_SIDE_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_MODE = 1'b1;

    localparam logic [7:0] SIDE_COUNT_RST  = 8'd6;
    localparam logic       VERTEX_MODE_RST = 1'b1;

    localparam logic [31:0] ATAN_TURN [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    // context carried alongside the vectoring CORDIC
    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic               mode;
        logic               odd;
        logic               degen;
        logic [31:0]        half;
        logic [30:0]        c;
        logic [31:0]        e;
    } ctx_a_t;

    // context carried alongside the dividers
    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic signed [31:0] cx_even;
        logic signed [31:0] cy_even;
        logic               dx_neg;
        logic               dy_neg;
        logic               mode;
        logic               odd;
        logic               degen;
        logic [31:0]        ang;
        logic [30:0]        rad_ev;
    } ctx_b_t;

    // cos of a turn fraction in Q30 by rotation CORDIC, clamped to [1, 2^30]
    function automatic logic [30:0] cos_q30(input logic [31:0] a, input int stages);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = longint'(INV_GAIN_Q30);
        y = 0;
        z = longint'({32'd0, a});
        for (int i = 0; i < stages; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'({32'd0, ATAN_TURN[i]});
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'({32'd0, ATAN_TURN[i]});
            end
        end
        if (x < 1)
            x = 1;
        if (x > longint'({32'd0, ONE_Q30}))
            x = longint'({32'd0, ONE_Q30});
        return x[30:0];
    endfunction

endpackage

@@ sv/polygon_from_two_points.sv @@
// Regular polygon from two picked points.
//
// Input channel: one word per pair of points (first_x/y, second_x/y, signed
// Q16.16), taken on a rising edge with in_valid high and in_stall low.
// Output channel: one word per input word, in order (center, start angle
// as a turn fraction times 2^32, vertex radius, degenerate flag), taken on
// a rising edge with out_valid high and out_stall low.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0: side_count, 1: vertex_mode). Write only while no word is in flight.
//
// Throughput: one word per cycle while in_stall is low. Results pass through
// the vectoring CORDIC (one stage per iteration) and the 32-stage restoring
// dividers behind it.
// Half angle and cosine per side count come from constant tables.
//
// Reset clears all valid bits and loads side_count = 6, vertex_mode = 1.
// While out_stall holds a result, the pipeline keeps moving as long as its
// last stage is empty; once a second result reaches that stage everything
// freezes and in_stall rises. Nothing is dropped or repeated.
module polygon_from_two_points #(
    parameter int CORDIC_STAGES = pfp_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [31:0]                  first_x,
    input  logic signed [31:0]                  first_y,
    input  logic signed [31:0]                  second_x,
    input  logic signed [31:0]                  second_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [31:0]                  center_x,
    output logic signed [31:0]                  center_y,
    output logic [31:0]                         start_angle,
    output logic [30:0]                         vertex_radius,
    output logic                                degenerate,
    input  logic                                cfg_we,
    input  logic [pfp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pfp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int DIV_LAT    = pfp_pkg::QUO_W + 1;
    localparam int CA_DEPTH   = CORDIC_STAGES + 2;
    localparam int PIPE_DEPTH = CORDIC_STAGES + 5 + DIV_LAT;
    localparam logic [30:0] RAD_MAX = '1;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -35'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // ---------------- configuration ----------------
    logic [7:0] side_count_reg;
    logic       vertex_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_count_reg  <= pfp_pkg::SIDE_COUNT_RST;
            vertex_mode_reg <= pfp_pkg::VERTEX_MODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pfp_pkg::REG_SIDE_COUNT:  side_count_reg  <= cfg_data;
                pfp_pkg::REG_VERTEX_MODE: vertex_mode_reg <= cfg_data[0];
            endcase
        end
    end

    // ---------------- per side count tables ----------------
    // Entries below three stand for a triangle.
    logic [31:0] half_rom [256];
    logic [30:0] cos_rom  [256];

    for (genvar n = 0; n < 256; n++)
    begin : g_rom
        localparam int unsigned NN = (n < 3) ? 3 : n;
        localparam logic [63:0] HV = (64'd4294967296 + 64'(NN)) / (64'(2 * NN));
        localparam logic [30:0] CV = pfp_pkg::cos_q30(HV[31:0], CORDIC_STAGES);
        assign half_rom[n] = HV[31:0];
        assign cos_rom[n]  = CV;
    end

    // ---------------- flow control ----------------
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  out_valid_reg;
    logic                  adv;
    logic                  load;

    // freeze only when the held result and the last stage both carry words
    assign adv      = !(out_valid_reg && out_stall && vld_reg[PIPE_DEPTH-1]);
    assign load     = adv && vld_reg[PIPE_DEPTH-1];
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                vld_reg <= {vld_reg[PIPE_DEPTH-2:0], in_valid};
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- stage 0: differences and table lookup ----------------
    pfp_pkg::ctx_a_t ctxa_reg [CA_DEPTH];
    pfp_pkg::ctx_a_t ctx0_next;

    always_comb
    begin
        ctx0_next.x1    = first_x;
        ctx0_next.y1    = first_y;
        ctx0_next.x2    = second_x;
        ctx0_next.y2    = second_y;
        ctx0_next.dx    = 33'(second_x) - 33'(first_x);
        ctx0_next.dy    = 33'(second_y) - 33'(first_y);
        ctx0_next.mode  = vertex_mode_reg;
        ctx0_next.odd   = (side_count_reg < 8'd3) ? 1'b1 : side_count_reg[0];
        ctx0_next.degen = (first_x == second_x) && (first_y == second_y);
        ctx0_next.half  = half_rom[side_count_reg];
        ctx0_next.c     = cos_rom[side_count_reg];
        ctx0_next.e     = pfp_pkg::ONE_Q30 + 32'(cos_rom[side_count_reg]);
    end

    // hold the context beside the CORDIC
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctxa_reg[0] <= ctx0_next;
            for (int k = 1; k < CA_DEPTH; k++)
                ctxa_reg[k] <= ctxa_reg[k-1];
        end
    end

    logic [34:0] cordic_mag;
    logic [31:0] cordic_phi;

    pfp_cordic_vec #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk (clk),
        .en  (adv),
        .dx  (ctxa_reg[0].dx),
        .dy  (ctxa_reg[0].dy),
        .mag (cordic_mag),
        .phi (cordic_phi)
    );

    // ---------------- M: gain and offset products, angle ----------------
    pfp_pkg::ctx_a_t ca;
    logic [32:0]     neg_dx;
    logic [32:0]     neg_dy;
    logic [31:0]     mag_x;
    logic [31:0]     mag_y;
    logic [31:0]     ang_next;

    assign ca     = ctxa_reg[CA_DEPTH-1];
    assign neg_dx = -ca.dx;
    assign neg_dy = -ca.dy;
    assign mag_x  = ca.dx[32] ? neg_dx[31:0] : ca.dx[31:0];
    assign mag_y  = ca.dy[32] ? neg_dy[31:0] : ca.dy[31:0];

    always_comb
    begin
        if (ca.degen)
            ang_next = '0;
        else if (ca.mode && !ca.odd)
            ang_next = cordic_phi;
        else if (ca.mode)
            ang_next = cordic_phi + pfp_pkg::HALF_TURN;
        else
            ang_next = cordic_phi + pfp_pkg::HALF_TURN + ca.half;
    end

    pfp_pkg::ctx_a_t ctx_m_reg;
    logic [63:0]     prod_len_reg;
    logic [62:0]     prod_x_m_reg;
    logic [62:0]     prod_y_m_reg;
    logic [31:0]     ang_m_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_m_reg    <= ca;
            prod_len_reg <= 64'(cordic_mag) * 64'(pfp_pkg::INV_GAIN_Q30);
            prod_x_m_reg <= 63'(mag_x) * 63'(ca.c);
            prod_y_m_reg <= 63'(mag_y) * 63'(ca.c);
            ang_m_reg    <= ang_next;
        end
    end

    // ---------------- R1: round the magnitude ----------------
    pfp_pkg::ctx_a_t ctx_r1_reg;
    logic [33:0]     len_reg;
    logic [62:0]     prod_x_r1_reg;
    logic [62:0]     prod_y_r1_reg;
    logic [31:0]     ang_r1_reg;
    logic [63:0]     len_sum;

    assign len_sum = prod_len_reg + 64'h2000_0000;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_r1_reg    <= ctx_m_reg;
            len_reg       <= len_sum[63:30];
            prod_x_r1_reg <= prod_x_m_reg;
            prod_y_r1_reg <= prod_y_m_reg;
            ang_r1_reg    <= ang_m_reg;
        end
    end

    // ---------------- R2: dividend setup ----------------
    pfp_pkg::ctx_a_t c1;
    pfp_pkg::ctx_b_t ctxb0_next;
    logic [32:0]     sum_x;
    logic [32:0]     sum_y;
    logic [34:0]     half_len;
    logic [64:0]     num_rad_next;
    logic [31:0]     den_rad_next;

    assign c1       = ctx_r1_reg;
    assign sum_x    = 33'(c1.x1) + 33'(c1.x2);
    assign sum_y    = 33'(c1.y1) + 33'(c1.y2);
    assign half_len = (35'(len_reg) + 35'd1) >> 1;

    always_comb
    begin
        if (c1.odd)
        begin
            num_rad_next = {1'b0, len_reg, 30'd0} + 65'(c1.e >> 1);
            den_rad_next = c1.e;
        end
        else
        begin
            num_rad_next = {2'b0, len_reg, 29'd0} + 65'(c1.c >> 1);
            den_rad_next = 32'(c1.c);
        end
        ctxb0_next.x1      = c1.x1;
        ctxb0_next.y1      = c1.y1;
        ctxb0_next.x2      = c1.x2;
        ctxb0_next.y2      = c1.y2;
        ctxb0_next.cx_even = sum_x[32:1];
        ctxb0_next.cy_even = sum_y[32:1];
        ctxb0_next.dx_neg  = c1.dx[32];
        ctxb0_next.dy_neg  = c1.dy[32];
        ctxb0_next.mode    = c1.mode;
        ctxb0_next.odd     = c1.odd;
        ctxb0_next.degen   = c1.degen;
        ctxb0_next.ang     = ang_r1_reg;
        ctxb0_next.rad_ev  = (half_len[34:31] != 4'd0) ? RAD_MAX : half_len[30:0];
    end

    pfp_pkg::ctx_b_t ctxb_reg [DIV_LAT+1];
    logic [64:0]     num_rad_reg;
    logic [64:0]     num_x_reg;
    logic [64:0]     num_y_reg;
    logic [31:0]     den_rad_reg;
    logic [31:0]     den_e_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_rad_reg <= num_rad_next;
            den_rad_reg <= den_rad_next;
            num_x_reg   <= 65'(prod_x_r1_reg) + 65'(c1.e >> 1);
            num_y_reg   <= 65'(prod_y_r1_reg) + 65'(c1.e >> 1);
            den_e_reg   <= c1.e;
            ctxb_reg[0] <= ctxb0_next;
            for (int k = 1; k <= DIV_LAT; k++)
                ctxb_reg[k] <= ctxb_reg[k-1];
        end
    end

    // ---------------- dividers ----------------
    logic [31:0] q_rad;
    logic [31:0] q_x;
    logic [31:0] q_y;
    logic        ovf_rad;
    logic        ovf_x;
    logic        ovf_y;

    pfp_div_pipe u_div_rad (
        .clk (clk), .en (adv), .num (num_rad_reg), .den (den_rad_reg),
        .quo (q_rad), .ovf (ovf_rad)
    );

    pfp_div_pipe u_div_x (
        .clk (clk), .en (adv), .num (num_x_reg), .den (den_e_reg),
        .quo (q_x), .ovf (ovf_x)
    );

    pfp_div_pipe u_div_y (
        .clk (clk), .en (adv), .num (num_y_reg), .den (den_e_reg),
        .quo (q_y), .ovf (ovf_y)
    );

    // ---------------- final: centers and radius ----------------
    pfp_pkg::ctx_b_t    cb;
    logic signed [33:0] ox;
    logic signed [33:0] oy;
    logic signed [34:0] cx_wide;
    logic signed [34:0] cy_wide;
    logic signed [31:0] cx_next;
    logic signed [31:0] cy_next;
    logic [30:0]        rad_next;

    assign cb = ctxb_reg[DIV_LAT];

    always_comb
    begin
        // offsets never exceed the difference, so their overflow flags stay low
        ox = cb.dx_neg ? -34'(q_x) : 34'(q_x);
        oy = cb.dy_neg ? -34'(q_y) : 34'(q_y);
        if (cb.mode)
        begin
            cx_wide = 35'(cb.x2) - 35'(ox);
            cy_wide = 35'(cb.y2) - 35'(oy);
        end
        else
        begin
            cx_wide = 35'(cb.x1) + 35'(ox);
            cy_wide = 35'(cb.y1) + 35'(oy);
        end

        priority if (cb.degen)
        begin
            cx_next  = cb.x1;
            cy_next  = cb.y1;
            rad_next = '0;
        end
        else if (!cb.odd)
        begin
            cx_next  = cb.cx_even;
            cy_next  = cb.cy_even;
            rad_next = cb.mode ? cb.rad_ev
                     : ((ovf_rad || q_rad[31]) ? RAD_MAX : q_rad[30:0]);
        end
        else
        begin
            cx_next  = sat32(cx_wide);
            cy_next  = sat32(cy_wide);
            rad_next = (ovf_rad || q_rad[31]) ? RAD_MAX : q_rad[30:0];
        end
    end

    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic [31:0]        start_angle_reg;
    logic [30:0]        vertex_radius_reg;
    logic               degenerate_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            center_x_reg      <= cx_next;
            center_y_reg      <= cy_next;
            start_angle_reg   <= cb.ang;
            vertex_radius_reg <= rad_next;
            degenerate_reg    <= cb.degen;
        end
    end

    assign out_valid     = out_valid_reg;
    assign center_x      = center_x_reg;
    assign center_y      = center_y_reg;
    assign start_angle   = start_angle_reg;
    assign vertex_radius = vertex_radius_reg;
    assign degenerate    = degenerate_reg;

    // ---------------- checks ----------------
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && vld_reg[PIPE_DEPTH-1]))
        else $error("input stalled without a blocked result");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted word missing from first stage");

    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> out_valid_reg)
        else $error("held result lost during freeze");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && degenerate_reg) |->
            (start_angle_reg == 32'd0 && vertex_radius_reg == 31'd0))
        else $error("degenerate result with nonzero angle or radius");

    a_offset_fit: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[PIPE_DEPTH-1] && !cb.degen && cb.odd) |-> (!ovf_x && !ovf_y))
        else $error("center offset quotient overflow");

endmodule

@@ sv/pfp_cordic_vec.sv @@
module pfp_cordic_vec #(
    parameter int STAGES = pfp_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [32:0] dx,
    input  logic signed [32:0] dy,
    output logic [34:0]        mag,
    output logic [31:0]        phi
);

    localparam int W = pfp_pkg::CORDIC_W;

    logic signed [W-1:0] x_reg [STAGES+1];
    logic signed [W-1:0] y_reg [STAGES];
    logic [31:0]         z_reg [STAGES+1];

    // fold the left half plane onto the right one
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dx[32])
            begin
                x_reg[0] <= -W'(dx);
                y_reg[0] <= -W'(dy);
                z_reg[0] <= pfp_pkg::HALF_TURN;
            end
            else
            begin
                x_reg[0] <= W'(dx);
                y_reg[0] <= W'(dy);
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        logic signed [W-1:0] xs;
        logic signed [W-1:0] ys;
        logic signed [W-1:0] x_next;
        logic signed [W-1:0] y_next;
        logic [31:0]         z_next;

        always_comb
        begin
            xs = x_reg[k] >>> k;
            ys = y_reg[k] >>> k;
            if (!y_reg[k][W-1])
            begin
                x_next = x_reg[k] + ys;
                y_next = y_reg[k] - xs;
                z_next = z_reg[k] + pfp_pkg::ATAN_TURN[k];
            end
            else
            begin
                x_next = x_reg[k] - ys;
                y_next = y_reg[k] + xs;
                z_next = z_reg[k] - pfp_pkg::ATAN_TURN[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k+1] <= x_next;
                z_reg[k+1] <= z_next;
            end
        end

        if (k + 1 < STAGES)
        begin : g_y
            always_ff @(posedge clk)
            begin
                if (en)
                    y_reg[k+1] <= y_next;
            end
        end
    end

    assign mag = x_reg[STAGES][34:0];
    assign phi = z_reg[STAGES];

endmodule

@@ sv/pfp_div_pipe.sv @@
module pfp_div_pipe #(
    parameter int NUM_W = pfp_pkg::NUM_W,
    parameter int QUO_W = pfp_pkg::QUO_W,
    parameter int DEN_W = pfp_pkg::DEN_W
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic             ovf
);

    localparam int HI_W = NUM_W - QUO_W;

    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] low_reg [QUO_W];
    logic [QUO_W-1:0] q_reg   [QUO_W+1];
    logic             ovf_reg [QUO_W+1];

    logic [HI_W-1:0] hi;
    assign hi = num[NUM_W-1:QUO_W];

    // entry: flag quotients that do not fit, keep the partial remainder
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= hi[DEN_W-1:0];
            den_reg[0] <= den;
            low_reg[0] <= num[QUO_W-1:0];
            q_reg[0]   <= '0;
            ovf_reg[0] <= (hi >= HI_W'(den));
        end
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_bit
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[k], low_reg[k][QUO_W-1-k]};
            diff     = trial - {1'b0, den_reg[k]};
            ge       = (trial >= {1'b0, den_reg[k]});
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k+1]   <= {q_reg[k][QUO_W-2:0], ge};
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end

        if (k + 1 < QUO_W)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= rem_next;
                    den_reg[k+1] <= den_reg[k];
                    low_reg[k+1] <= low_reg[k];
                end
            end
        end
    end

    assign quo = q_reg[QUO_W];
    assign ovf = ovf_reg[QUO_W];

endmodule

@@ sim/tb_polygon_from_two_points.sv @@
`timescale 1ns / 1ps

module tb_polygon_from_two_points;

    localparam int STAGES      = pfp_pkg::CORDIC_STAGES_DEF;
    localparam int LATENCY     = STAGES + 39;
    localparam int LONG_HOLD   = 300;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // one pair of picked points plus the idle gap the sender inserts before it
    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        int                 gap;
    } point_pair_t;

    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [31:0]        ang;
        logic [30:0]        rad;
        logic               degen;
    } polygon_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [31:0]        start_angle;
    logic [30:0]        vertex_radius;
    logic               degenerate;
    logic               cfg_we;
    logic [pfp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pfp_pkg::CFG_DATA_W-1:0] cfg_data;

    // predictor copy of the configuration registers
    logic [7:0] side_reg;
    logic       mode_reg;

    point_pair_t pending_pairs[$];
    polygon_t    expected_polygons[$];

    bit  word_taken;      // input word accepted at the last rising edge
    bit  result_taken;    // result accepted at the last rising edge
    bit  idle_on;         // random gaps and stalls enabled for this phase
    int  hold_trigger;    // bumped to request a long receiver hold-off
    int  hold_seen;
    int  hold_left;
    int  rx_wait;
    int  errors;
    int  words_sent;
    int  results_checked;
    int  degen_seen;
    int  settings_run;

    polygon_from_two_points dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .first_x       (first_x),
        .first_y       (first_y),
        .second_x      (second_x),
        .second_y      (second_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .center_x      (center_x),
        .center_y      (center_y),
        .start_angle   (start_angle),
        .vertex_radius (vertex_radius),
        .degenerate    (degenerate),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Rotation CORDIC: cosine of a turn fraction in Q30, clamped to [1, 2^30].
    function automatic longint cos_of_turn(input logic [31:0] a);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = longint'(pfp_pkg::INV_GAIN_Q30);
        y = 0;
        z = longint'({32'd0, a});
        for (int i = 0; i < STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= longint'({32'd0, pfp_pkg::ATAN_TURN[i]});
            end
            else
            begin
                x += ys;
                y -= xs;
                z += longint'({32'd0, pfp_pkg::ATAN_TURN[i]});
            end
        end
        if (x < 1)
            x = 1;
        if (x > longint'({32'd0, pfp_pkg::ONE_Q30}))
            x = longint'({32'd0, pfp_pkg::ONE_Q30});
        return x;
    endfunction

    // Divide, rounding half away from zero.
    function automatic longint round_quot(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(S32_MAX))
            return S32_MAX;
        if (v < longint'(S32_MIN))
            return S32_MIN;
        return v[31:0];
    endfunction

    // Center, starting vertex angle and radius for the current side count and mode.
    function automatic polygon_t solve_polygon(input point_pair_t pp);
        polygon_t          res;
        longint            x1;
        longint            y1;
        longint            x2;
        longint            y2;
        longint            dx;
        longint            dy;
        longint            vx;
        longint            vy;
        longint            xs;
        longint            ys;
        longint            c;
        longint            e;
        longint            ox;
        longint            oy;
        longint            cx;
        longint            cy;
        longint unsigned   len;
        longint unsigned   rad;
        logic [31:0]       phi;
        logic [31:0]       half;
        int unsigned       n;
        x1 = longint'(pp.px);
        y1 = longint'(pp.py);
        x2 = longint'(pp.sx);
        y2 = longint'(pp.sy);
        dx = x2 - x1;
        dy = y2 - y1;
        res.degen = 1'b0;
        if (dx == 0 && dy == 0)
        begin
            res.cx    = pp.px;
            res.cy    = pp.py;
            res.ang   = '0;
            res.rad   = '0;
            res.degen = 1'b1;
            return res;
        end

        // vectoring CORDIC: angle and scaled length of the difference vector
        vx  = dx;
        vy  = dy;
        phi = '0;
        if (vx < 0)
        begin
            vx  = -vx;
            vy  = -vy;
            phi = pfp_pkg::HALF_TURN;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy >= 0)
            begin
                vx += ys;
                vy -= xs;
                phi = phi + pfp_pkg::ATAN_TURN[i];
            end
            else
            begin
                vx -= ys;
                vy += xs;
                phi = phi - pfp_pkg::ATAN_TURN[i];
            end
        end
        len = (longint'(vx) * longint'(pfp_pkg::INV_GAIN_Q30) + (64'd1 << 29)) >> 30;

        n    = (side_reg < 8'd3) ? 3 : side_reg;
        half = 32'((64'd4294967296 + n) / (2 * n));
        c    = cos_of_turn(half);

        if (n % 2 == 0)
        begin
            cx = (x1 + x2) >>> 1;
            cy = (y1 + y2) >>> 1;
            if (mode_reg)
            begin
                res.ang = phi;
                rad = (len + 1) >> 1;
            end
            else
            begin
                res.ang = phi + pfp_pkg::HALF_TURN + half;
                rad = ((len << 29) + longint'(c / 2)) / longint'(c);
            end
        end
        else
        begin
            e  = longint'(pfp_pkg::ONE_Q30) + c;
            ox = round_quot(dx * c, e);
            oy = round_quot(dy * c, e);
            if (mode_reg)
            begin
                cx = x2 - ox;
                cy = y2 - oy;
                res.ang = phi + pfp_pkg::HALF_TURN;
            end
            else
            begin
                cx = x1 + ox;
                cy = y1 + oy;
                res.ang = phi + pfp_pkg::HALF_TURN + half;
            end
            rad = ((len << 30) + longint'(e / 2)) / longint'(e);
        end
        if (rad > 64'h7FFF_FFFF)
            rad = 64'h7FFF_FFFF;
        res.cx  = clamp32(cx);
        res.cy  = clamp32(cy);
        res.rad = rad[30:0];
        return res;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch on result %0d: %s got 0x%0h, want 0x%0h",
                 results_checked, field, got, want);
        errors++;
    endtask

    // Sample both channels at the rising edge: predict on input words,
    // check output words against the oldest prediction.
    always @(posedge clk)
    begin
        polygon_t want;
        point_pair_t pp;
        word_taken   = rst_n && in_valid && !in_stall;
        result_taken = rst_n && out_valid && !out_stall;
        if (word_taken)
        begin
            pp.px = first_x;
            pp.py = first_y;
            pp.sx = second_x;
            pp.sy = second_y;
            pp.gap = 0;
            expected_polygons.push_back(solve_polygon(pp));
            words_sent++;
        end
        if (result_taken)
        begin
            if (expected_polygons.size() == 0)
            begin
                $display("result with no word outstanding");
                errors++;
            end
            else
            begin
                want = expected_polygons.pop_front();
                if (center_x !== want.cx)
                    report_mismatch("center_x", center_x, want.cx);
                if (center_y !== want.cy)
                    report_mismatch("center_y", center_y, want.cy);
                if (start_angle !== want.ang)
                    report_mismatch("start_angle", start_angle, want.ang);
                if (vertex_radius !== want.rad)
                    report_mismatch("vertex_radius", vertex_radius, want.rad);
                if (degenerate !== want.degen)
                    report_mismatch("degenerate", degenerate, want.degen);
                if (want.degen)
                    degen_seen++;
            end
            results_checked++;
        end
    end

    // Sender: hold a stalled word, otherwise burn the gap, then present the next.
    always @(negedge clk)
    begin
        logic next_valid;
        next_valid = in_valid;
        if (!rst_n)
            next_valid = 1'b0;
        else if (!in_valid || word_taken)
        begin
            next_valid = 1'b0;
            if (pending_pairs.size() != 0)
            begin
                if (pending_pairs[0].gap > 0)
                    pending_pairs[0].gap--;
                else
                begin
                    first_x    <= pending_pairs[0].px;
                    first_y    <= pending_pairs[0].py;
                    second_x   <= pending_pairs[0].sx;
                    second_y   <= pending_pairs[0].sy;
                    next_valid = 1'b1;
                    void'(pending_pairs.pop_front());
                end
            end
        end
        in_valid <= next_valid;
    end

    // Receiver: a long hold-off on request, else a fresh random wait per result.
    always @(negedge clk)
    begin
        logic stall;
        if (hold_trigger != hold_seen)
        begin
            hold_seen = hold_trigger;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            stall = 1'b1;
        end
        else
        begin
            if (result_taken)
                rx_wait = idle_on ? $urandom_range(0, 6) : 0;
            if (rx_wait > 0)
            begin
                rx_wait--;
                stall = 1'b1;
            end
            else
                stall = 1'b0;
        end
        out_stall <= stall;
    end

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return S32_MAX;
            1: return S32_MIN;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic point_pair_t random_pair();
        point_pair_t pp;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        pp.px = $urandom;
        pp.py = $urandom;
        case (sel)
            0:
            begin
                pp.sx = pp.px;
                pp.sy = pp.py;
            end
            1:
            begin
                pp.px = pick_coord();
                pp.py = pick_coord();
                pp.sx = pick_coord();
                pp.sy = pick_coord();
            end
            2, 3, 4:
            begin
                // nearby points, typical of interactive picking
                pp.px = $signed(pp.px) >>> 4;
                pp.py = $signed(pp.py) >>> 4;
                pp.sx = pp.px + $signed($urandom_range(0, 2097152)) - 32'sd1048576;
                pp.sy = pp.py + $signed($urandom_range(0, 2097152)) - 32'sd1048576;
            end
            5, 6:
            begin
                pp.px = $signed(pp.px) >>> 3;
                pp.py = $signed(pp.py) >>> 3;
                pp.sx = $signed($urandom) >>> 3;
                pp.sy = $signed($urandom) >>> 3;
            end
            default:
            begin
                pp.sx = $urandom;
                pp.sy = $urandom;
            end
        endcase
        pp.gap = idle_on ? $urandom_range(0, 6) : 0;
        return pp;
    endfunction

    task automatic queue_pair(input logic signed [31:0] px, input logic signed [31:0] py,
                              input logic signed [31:0] sx, input logic signed [31:0] sy);
        point_pair_t pp;
        pp.px  = px;
        pp.py  = py;
        pp.sx  = sx;
        pp.sy  = sy;
        pp.gap = idle_on ? $urandom_range(0, 6) : 0;
        pending_pairs.push_back(pp);
    endtask

    // Extremes, coincident points, axis directions and saturating spans.
    task automatic queue_directed();
        queue_pair(0, 0, 0, 0);
        queue_pair(S32_MAX, S32_MIN, S32_MAX, S32_MIN);
        queue_pair(0, 0, 32'sd65536, 0);
        queue_pair(0, 0, 0, 32'sd65536);
        queue_pair(0, 0, -32'sd65536, 0);
        queue_pair(0, 0, 0, -32'sd65536);
        queue_pair(0, 0, 1, 1);
        queue_pair(S32_MIN, S32_MIN, S32_MAX, S32_MAX);
        queue_pair(S32_MAX, S32_MAX, S32_MIN, S32_MIN);
        queue_pair(S32_MIN, S32_MAX, S32_MAX, S32_MIN);
        queue_pair(S32_MAX, 0, S32_MIN, 0);
        queue_pair(-32'sd1, -32'sd1, 0, 0);
    endtask

    task automatic write_reg(input logic [pfp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == pfp_pkg::REG_SIDE_COUNT)
            side_reg = value;
        else
            mode_reg = value[0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every word has gone in and come back, then let the pipe drain.
    task automatic wait_idle();
        wait (pending_pairs.size() == 0 && !in_valid);
        wait (expected_polygons.size() == 0);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    task automatic run_phase(input logic [7:0] sides, input bit mode, input int count,
                             input bit directed, input bit pressure);
        wait_idle();
        // upper data bits are don't-care for the mode register
        write_reg(pfp_pkg::REG_SIDE_COUNT, sides);
        write_reg(pfp_pkg::REG_VERTEX_MODE, {7'($urandom_range(0, 127)), mode});
        settings_run++;
        idle_on = pressure ? 1'b0 : ($urandom_range(0, 3) != 0);
        if (directed)
            queue_directed();
        if (pressure)
            hold_trigger++;
        repeat (count)
            pending_pairs.push_back(random_pair());
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        out_stall  = 1'b0;
        first_x    = '0;
        first_y    = '0;
        second_x   = '0;
        second_y   = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        side_reg   = pfp_pkg::SIDE_COUNT_RST;
        mode_reg   = pfp_pkg::VERTEX_MODE_RST;
        idle_on    = 1'b1;
        hold_trigger = 0;
        hold_seen  = 0;
        hold_left  = 0;
        rx_wait    = 0;
        errors     = 0;
        words_sent = 0;
        results_checked = 0;
        degen_seen = 0;
        settings_run = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults first, before any register write
        queue_directed();
        repeat (60)
            pending_pairs.push_back(random_pair());

        run_phase(8'd6, 1'b0, 90, 1'b0, 1'b0);
        run_phase(8'd3, 1'b0, 90, 1'b1, 1'b0);
        run_phase(8'd3, 1'b1, 90, 1'b0, 1'b0);
        run_phase(8'd255, 1'b0, 80, 1'b0, 1'b0);
        run_phase(8'd255, 1'b1, 80, 1'b0, 1'b0);
        run_phase(8'd254, 1'b0, 80, 1'b0, 1'b0);
        run_phase(8'd0, 1'b1, 60, 1'b0, 1'b0);
        run_phase(8'd2, 1'b0, 60, 1'b0, 1'b0);
        run_phase(8'd1, 1'b1, 40, 1'b0, 1'b0);
        run_phase(8'd4, 1'b1, 200, 1'b0, 1'b1);
        for (int k = 0; k < 6; k++)
            run_phase(8'($urandom_range(3, 255)), 1'($urandom_range(0, 1)), 80,
                      1'b0, 1'b0);
        wait_idle();

        $display("covered %0d words over %0d register settings, %0d degenerate pairs",
                 words_sent, settings_run, degen_seen);
        $display("checked %0d results, %0d mismatches", results_checked, errors);
        if (errors == 0 && expected_polygons.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout with %0d results outstanding", expected_polygons.size());
        $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
sv/pfp_pkg.sv
sv/pfp_cordic_vec.sv
sv/pfp_div_pipe.sv
sv/polygon_from_two_points.sv
sim/tb_polygon_from_two_points.sv
